>>> hw/rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared constants, codes and controller/datapath interface types for the
// contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int CELLS = 1024;
  localparam int IDX_W = $clog2(CELLS);
  localparam int LEN_W = $clog2(CELLS + 1);

  localparam int ID_W    = 16;
  localparam int SIZE_W  = 11;
  localparam int OUT_IDX_W = 10;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // operation codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // placement policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  // unused code, behaves as first fit
  localparam logic [1:0] POL_SPARE = 2'd3;

  typedef struct packed {
    logic init_wr;     // clearing pass: zero one cell
    logic load;        // capture a new word
    logic scan_rd;     // read the next cell of the scan
    logic final_eval;  // close the trailing free run
    logic wr_run;      // write one cell of the chosen run
    logic respond;     // drive the result strobe
  } cmd_t;

  typedef struct packed {
    logic idx_last;    // scan or clearing index at the last cell
    logic bad_req;     // allocate size is zero or exceeds the store
    logic is_clear;    // captured word is a clear
    logic have;        // a run was chosen
    logic wr_last;     // last cell of the run being written
  } sts_t;

  function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer for the allocator: clearing pass, store scan, run write and
// result strobe.
// ----------------------------------------------------------------------------
module cfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  cfa_pkg::sts_t sts,
  output cfa_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.bad_req ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_FLUSH;
        end
      end
      // last read word is processed here
      S_FLUSH: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.final_eval = 1'b1;
        state_nxt      = S_RESP;
        if (!sts.is_clear) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!sts.have) begin
          state_nxt = S_RESP;
        end else begin
          cmd.wr_run = 1'b1;
          if (sts.wr_last) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hw/rtl/cfa_dpath.sv
// ----------------------------------------------------------------------------
// cfa_dpath
// Cell store, scan pipeline, free run tracking, clear run tracking, run
// writer, policy register and result registers.
// ----------------------------------------------------------------------------
module cfa_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfa_pkg::cmd_t                  cmd,
  output cfa_pkg::sts_t                  sts,
  input  logic                           in_mode,
  input  logic [cfa_pkg::ID_W-1:0]       in_owner_id,
  input  logic [cfa_pkg::SIZE_W-1:0]     in_request_size,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_fit_policy,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [cfa_pkg::OUT_IDX_W-1:0]  out_start_index
);

  localparam logic [cfa_pkg::IDX_W-1:0] IDX_LAST = cfa_pkg::IDX_W'(cfa_pkg::CELLS - 1);

  logic [cfa_pkg::ID_W-1:0]  cell_owner_r [cfa_pkg::CELLS];

  logic [1:0]                policy_r;
  logic                      mode_r;
  logic [cfa_pkg::ID_W-1:0]  id_r;
  logic [cfa_pkg::LEN_W-1:0] need_r;

  logic [cfa_pkg::IDX_W-1:0] idx_r;
  logic [cfa_pkg::IDX_W-1:0] proc_idx_r;
  logic                      pvld_r;
  logic [cfa_pkg::ID_W-1:0]  rd_data_r;

  logic [cfa_pkg::IDX_W-1:0] run_start_r;
  logic [cfa_pkg::LEN_W-1:0] run_len_r;
  logic                      have_r;
  logic [cfa_pkg::IDX_W-1:0] best_start_r;
  logic [cfa_pkg::LEN_W-1:0] best_len_r;

  logic                      found_r;
  logic                      clr_end_r;
  logic [cfa_pkg::IDX_W-1:0] clr_start_r;

  logic [cfa_pkg::IDX_W-1:0] wr_ptr_r;
  logic [cfa_pkg::LEN_W-1:0] wr_cnt_r;

  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic [cfa_pkg::OUT_IDX_W-1:0] out_start_r;

  logic [31:0]               size_ext;
  logic                      take;
  logic                      is_free;
  logic                      hit;
  logic                      clr_wr;
  logic                      mem_we;
  logic [cfa_pkg::IDX_W-1:0] mem_wa;
  logic [cfa_pkg::ID_W-1:0]  mem_wd;

  assign size_ext = 32'(in_request_size);

  assign sts.bad_req  = (in_mode == cfa_pkg::MODE_ALLOC) &&
                        ((in_request_size == '0) || (size_ext > 32'(cfa_pkg::CELLS)));
  assign sts.idx_last = (idx_r == IDX_LAST);
  assign sts.is_clear = (mode_r == cfa_pkg::MODE_CLEAR);
  assign sts.have     = have_r;
  assign sts.wr_last  = (wr_cnt_r == cfa_pkg::LEN_W'(1));

  // does the free run that just closed beat the current choice
  assign take = (run_len_r >= need_r) &&
                (!have_r ||
                 ((policy_r == cfa_pkg::POL_BEST) && (run_len_r < best_len_r)) ||
                 ((policy_r == cfa_pkg::POL_WORST) && (run_len_r > best_len_r)));

  assign is_free = (rd_data_r == '0);
  assign hit     = (rd_data_r == id_r);
  assign clr_wr  = pvld_r && sts.is_clear && hit && (!found_r || !clr_end_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    if (cmd.init_wr) begin
      mem_we = 1'b1;
    end else if (clr_wr) begin
      mem_we = 1'b1;
      mem_wa = proc_idx_r;
    end else if (cmd.wr_run) begin
      mem_we = 1'b1;
      mem_wa = wr_ptr_r;
      mem_wd = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_owner_r[mem_wa] <= mem_wd;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= cell_owner_r[idx_r];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= cfa_pkg::POL_FIRST;
      idx_r       <= '0;
      pvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy_r <= (cfg_fit_policy == cfa_pkg::POL_SPARE) ? cfa_pkg::POL_FIRST
                                                            : cfg_fit_policy;
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.init_wr || cmd.scan_rd) begin
        idx_r <= sts.idx_last ? '0 : idx_r + 1'b1;
      end
      pvld_r      <= cmd.scan_rd;
      out_valid_r <= cmd.respond;
    end
  end

  // payload and tracking registers
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      proc_idx_r <= idx_r;
    end
    if (cmd.load) begin
      mode_r    <= in_mode;
      id_r      <= in_owner_id;
      need_r    <= size_ext[cfa_pkg::LEN_W-1:0];
      run_len_r <= '0;
      have_r    <= 1'b0;
      found_r   <= 1'b0;
      clr_end_r <= 1'b0;
    end else if (pvld_r) begin
      if (sts.is_clear) begin
        if (!found_r && hit) begin
          found_r     <= 1'b1;
          clr_start_r <= proc_idx_r;
        end else if (found_r && !hit) begin
          clr_end_r <= 1'b1;
        end
      end else if (is_free) begin
        if (run_len_r == '0) begin
          run_start_r <= proc_idx_r;
        end
        run_len_r <= run_len_r + 1'b1;
      end else begin
        if (take) begin
          have_r       <= 1'b1;
          best_start_r <= run_start_r;
          best_len_r   <= run_len_r;
        end
        run_len_r <= '0;
      end
    end else if (cmd.final_eval) begin
      // the end of the store closes a trailing free run
      if (take && !sts.is_clear) begin
        have_r       <= 1'b1;
        best_start_r <= run_start_r;
        best_len_r   <= run_len_r;
      end
      run_len_r <= '0;
      wr_ptr_r  <= (take && !sts.is_clear) ? run_start_r : best_start_r;
      wr_cnt_r  <= need_r;
    end else if (cmd.wr_run) begin
      wr_ptr_r <= wr_ptr_r + 1'b1;
      wr_cnt_r <= wr_cnt_r - 1'b1;
    end
    if (cmd.respond) begin
      out_status_r <= cfa_pkg::ST_NO_SPACE;
      out_start_r  <= '0;
      if (sts.is_clear) begin
        if (found_r) begin
          out_status_r <= cfa_pkg::ST_DONE;
          out_start_r  <= cfa_pkg::out_index(clr_start_r);
        end else begin
          out_status_r <= cfa_pkg::ST_NOT_FOUND;
        end
      end else if (have_r) begin
        out_status_r <= cfa_pkg::ST_DONE;
        out_start_r  <= cfa_pkg::out_index(best_start_r);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_index = out_start_r;

endmodule

>>> hw/rtl/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Contiguous run allocator over a store of owner ids with first, best and
// worst fit placement and clear by owner id.
// ----------------------------------------------------------------------------
// after reset the block runs a clearing pass over all CELLS cells (1024) with
// busy high. a word is taken when start is high and busy is low. every word
// but an allocate of size zero or larger than the store scans the whole store
// through the single read port, one cell a cycle; an allocate that places a
// run then writes request_size cells, and an allocate of size zero or larger
// than the store answers without a scan.
// the result is shown for exactly one cycle with out_valid high and must be
// taken then; out_valid is always seen while busy is low. the policy register
// is always ready and should only be written while busy is low.
module contiguous_fit_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [cfa_pkg::ID_W-1:0]       in_owner_id,
  input  logic [cfa_pkg::SIZE_W-1:0]     in_request_size,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [cfa_pkg::OUT_IDX_W-1:0]  out_start_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_fit_policy
);

  cfa_pkg::cmd_t cmd;
  cfa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  cfa_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_owner_id     (in_owner_id),
    .in_request_size (in_request_size),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_fit_policy  (cfg_fit_policy),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_index (out_start_index)
  );

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != cfa_pkg::ST_DONE)) |-> (out_start_index == '0))
    else $error("failed result with nonzero start index");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Runs allocate and clear words through contiguous_fit_allocator under every
// placement policy, keeps its own picture of the cell store, and compares each
// reply word field by field with what that picture predicts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TIMEOUT_CYCLES = 5_000_000;
  localparam int PHASE_WORDS = 86;

  typedef struct {
    logic [1:0]                    status;
    logic [cfa_pkg::OUT_IDX_W-1:0] first_cell;
  } reply_t;

  class fit_tracker;
    logic [cfa_pkg::ID_W-1:0] owner_map [cfa_pkg::CELLS];
    logic [1:0]               policy;
    reply_t                   replies [$];
    int                       mismatches;

    function new();
      foreach (owner_map[i]) owner_map[i] = '0;
      policy = cfa_pkg::POL_FIRST;
      mismatches = 0;
    endfunction

    function void set_policy(logic [1:0] p);
      policy = (p == cfa_pkg::POL_SPARE) ? cfa_pkg::POL_FIRST : p;
    endfunction

    function void complain(string what, int want, int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endfunction

    function reply_t place_run(logic [cfa_pkg::ID_W-1:0] id,
                               logic [cfa_pkg::SIZE_W-1:0] need);
      reply_t r;
      bit     have, free_cell, wins;
      int     run_start, run_len, best_start, best_len;
      r.status = cfa_pkg::ST_NO_SPACE;
      r.first_cell = '0;
      have = 0;
      run_start = 0;
      run_len = 0;
      best_start = 0;
      best_len = 0;
      if (need == 0 || need > cfa_pkg::CELLS) return r;
      // one extra step past the last cell closes a trailing free run
      for (int i = 0; i <= cfa_pkg::CELLS; i++) begin
        free_cell = 0;
        if (i < cfa_pkg::CELLS) free_cell = (owner_map[i] == '0);
        if (free_cell) begin
          if (run_len == 0) run_start = i;
          run_len++;
        end else begin
          wins = (run_len >= int'(need)) && (!have ||
                 (policy == cfa_pkg::POL_BEST && run_len < best_len) ||
                 (policy == cfa_pkg::POL_WORST && run_len > best_len));
          if (wins) begin
            have = 1;
            best_start = run_start;
            best_len = run_len;
          end
          run_len = 0;
        end
      end
      if (!have) return r;
      for (int i = 0; i < int'(need); i++) owner_map[best_start + i] = id;
      r.status = cfa_pkg::ST_DONE;
      r.first_cell = cfa_pkg::OUT_IDX_W'(best_start);
      return r;
    endfunction

    function reply_t free_run(logic [cfa_pkg::ID_W-1:0] id);
      reply_t r;
      int     j;
      r.status = cfa_pkg::ST_NOT_FOUND;
      r.first_cell = '0;
      for (int i = 0; i < cfa_pkg::CELLS; i++) begin
        if (owner_map[i] == id) begin
          j = i;
          while (j < cfa_pkg::CELLS) begin
            if (owner_map[j] != id) break;
            owner_map[j] = '0;
            j++;
          end
          r.status = cfa_pkg::ST_DONE;
          r.first_cell = cfa_pkg::OUT_IDX_W'(i);
          return r;
        end
      end
      return r;
    endfunction

    function void note_word(logic mode, logic [cfa_pkg::ID_W-1:0] id,
                            logic [cfa_pkg::SIZE_W-1:0] size);
      if (mode == cfa_pkg::MODE_CLEAR) replies.push_back(free_run(id));
      else replies.push_back(place_run(id, size));
    endfunction

    function void check_reply(logic [1:0] status,
                              logic [cfa_pkg::OUT_IDX_W-1:0] first_cell);
      reply_t want;
      if (replies.size() == 0) begin
        complain("unexpected reply, status", -1, status);
        return;
      end
      want = replies.pop_front();
      if (status !== want.status) complain("status", want.status, status);
      if (first_cell !== want.first_cell)
        complain("start_index", want.first_cell, first_cell);
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_mode = cfa_pkg::MODE_ALLOC;
  logic [cfa_pkg::ID_W-1:0]      in_owner_id = '0;
  logic [cfa_pkg::SIZE_W-1:0]    in_request_size = '0;
  logic                          out_valid;
  logic [1:0]                    out_status;
  logic [cfa_pkg::OUT_IDX_W-1:0] out_start_index;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [1:0]                    cfg_fit_policy = cfa_pkg::POL_FIRST;

  fit_tracker               tracker;
  logic [cfa_pkg::ID_W-1:0] live_owners [$];
  int unsigned              cycles_run = 0;

  contiguous_fit_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_owner_id     (in_owner_id),
    .in_request_size (in_request_size),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_index (out_start_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_fit_policy  (cfg_fit_policy)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
  end

  // everything here sees the values from before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) tracker.note_word(in_mode, in_owner_id, in_request_size);
      if (out_valid) tracker.check_reply(out_status, out_start_index);
      if (cfg_valid && cfg_ready) tracker.set_policy(cfg_fit_policy);
    end
  end

  initial begin
    wait (cycles_run >= TIMEOUT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(logic mode, logic [cfa_pkg::ID_W-1:0] id,
                           logic [cfa_pkg::SIZE_W-1:0] size);
    start <= 1'b1;
    in_mode <= mode;
    in_owner_id <= id;
    in_request_size <= size;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (busy || tracker.replies.size() != 0);
  endtask

  task automatic write_policy(logic [1:0] p);
    wait_quiet();
    cfg_fit_policy <= p;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    int                         pick, alloc_odds, sz, slot;
    logic [cfa_pkg::ID_W-1:0]   id;
    logic [cfa_pkg::SIZE_W-1:0] size;
    pick = $urandom_range(0, 99);
    // lean toward clears once many owners are outstanding
    alloc_odds = (live_owners.size() < 12) ? 70 : 40;
    if (pick < alloc_odds) begin
      id = cfa_pkg::ID_W'($urandom_range(1, 65535));
      if (pick < 2) id = '0;
      sz = $urandom_range(0, 99);
      if (sz < 78) size = cfa_pkg::SIZE_W'($urandom_range(1, 48));
      else if (sz < 90) size = cfa_pkg::SIZE_W'($urandom_range(49, 300));
      else if (sz < 95) size = cfa_pkg::SIZE_W'($urandom_range(301, 1024));
      else if (sz < 98) size = cfa_pkg::SIZE_W'($urandom_range(1025, 2047));
      else size = '0;
      send_word(cfa_pkg::MODE_ALLOC, id, size);
      if (id != '0) live_owners.push_back(id);
    end else if (pick < 94 && live_owners.size() > 0) begin
      slot = $urandom_range(0, live_owners.size() - 1);
      id = live_owners[slot];
      live_owners.delete(slot);
      send_word(cfa_pkg::MODE_CLEAR, id, cfa_pkg::SIZE_W'($urandom));
    end else begin
      id = (pick < 97) ? cfa_pkg::ID_W'($urandom) : '0;
      send_word(cfa_pkg::MODE_CLEAR, id, cfa_pkg::SIZE_W'($urandom));
    end
  endtask

  initial begin
    logic [1:0] phase_policy [6];
    bit         gappy;
    tracker = new();
    phase_policy = '{cfa_pkg::POL_BEST, cfa_pkg::POL_WORST, cfa_pkg::POL_SPARE,
                     cfa_pkg::POL_FIRST, cfa_pkg::POL_WORST, cfa_pkg::POL_BEST};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty store, size limits, full store, trailing run, zero owner
    send_word(cfa_pkg::MODE_CLEAR, 16'h0005, 11'd0);
    send_word(cfa_pkg::MODE_CLEAR, 16'h0000, 11'd7);
    send_word(cfa_pkg::MODE_ALLOC, 16'h0001, 11'd0);
    send_word(cfa_pkg::MODE_ALLOC, 16'h0001, 11'd1025);
    send_word(cfa_pkg::MODE_ALLOC, 16'hFFFF, 11'd2047);
    send_word(cfa_pkg::MODE_ALLOC, 16'hFFFF, 11'd1024);
    send_word(cfa_pkg::MODE_CLEAR, 16'h0000, 11'd0);
    send_word(cfa_pkg::MODE_ALLOC, 16'h0002, 11'd1);
    send_word(cfa_pkg::MODE_CLEAR, 16'hFFFF, 11'h7FF);
    send_word(cfa_pkg::MODE_ALLOC, 16'h0001, 11'd100);
    send_word(cfa_pkg::MODE_ALLOC, 16'h8000, 11'd50);
    send_word(cfa_pkg::MODE_ALLOC, 16'h00AA, 11'd200);
    send_word(cfa_pkg::MODE_ALLOC, 16'h0000, 11'd10);
    send_word(cfa_pkg::MODE_CLEAR, 16'h8000, 11'd0);
    send_word(cfa_pkg::MODE_CLEAR, 16'h0000, 11'd0);
    send_word(cfa_pkg::MODE_ALLOC, 16'h5555, 11'd1);
    send_word(cfa_pkg::MODE_ALLOC, 16'h1234, 11'd674);
    send_word(cfa_pkg::MODE_CLEAR, 16'h1234, 11'd0);
    write_policy(cfa_pkg::POL_BEST);
    send_word(cfa_pkg::MODE_ALLOC, 16'h7FFF, 11'd20);
    write_policy(cfa_pkg::POL_WORST);
    send_word(cfa_pkg::MODE_ALLOC, 16'h3C3C, 11'd20);
    write_policy(cfa_pkg::POL_SPARE);
    send_word(cfa_pkg::MODE_ALLOC, 16'h0F0F, 11'd5);
    send_word(cfa_pkg::MODE_CLEAR, 16'h0001, 11'd0);
    send_word(cfa_pkg::MODE_ALLOC, 16'h00AA, 11'd10);
    send_word(cfa_pkg::MODE_CLEAR, 16'h00AA, 11'd0);
    live_owners = '{16'h5555, 16'h7FFF, 16'h3C3C, 16'h0F0F, 16'h00AA};

    foreach (phase_policy[p]) begin
      write_policy(phase_policy[p]);
      gappy = (p < 5) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (gappy && $urandom_range(0, 2) == 0) idle_for($urandom_range(1, 13));
        if (p == 2 && n == 40) wait_quiet();
        random_word();
      end
    end

    wait_quiet();
    repeat (cfa_pkg::CELLS + 64) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.replies.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
